[hw/rtl/elman_rnn_step_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ELMAN_RNN_STEP_UNIT_MACROS_SVH
`define ELMAN_RNN_STEP_UNIT_MACROS_SVH

// same-cycle implication
`define ERNN_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ERNN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/ernn_pkg.sv]
// ----------------------------------------------------------------------------
// ernn_pkg
// Shared types, codes and the tanh breakpoint table of the recurrent step unit.
// ----------------------------------------------------------------------------
package ernn_pkg;

  localparam int DataWidth = 16;
  localparam int FracBits  = 12;
  localparam int AccWidth  = 40;
  localparam int LenWidth  = 5;
  localparam int IdxWidth  = 4;
  localparam int ProdWidth = 2 * DataWidth;

  typedef enum logic [1:0] {
    OP_REC  = 2'd0,
    OP_INP  = 2'd1,
    OP_OUT  = 2'd2,
    OP_ELEM = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SRC_REC = 2'd0,
    SRC_INP = 2'd1,
    SRC_OUT = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    REG_INPUT_LEN  = 2'd0,
    REG_HIDDEN_LEN = 2'd1,
    REG_OUTPUT_LEN = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                clear;
    logic                load;
    logic                issue;
    src_t                src;
    logic [IdxWidth-1:0] row;
    logic [IdxWidth-1:0] col;
    logic                fin1;
    logic                fin2;
    logic                fin3;
    logic                copy;
    logic                emit;
    logic                last;
    logic [LenWidth-1:0] nh;
  } cmd_t;

  function automatic logic [12:0] tanh_point(input logic [4:0] idx);
    logic [12:0] p;
    case (idx)
      5'd0:    p = 13'd0;
      5'd1:    p = 13'd1003;
      5'd2:    p = 13'd1893;
      5'd3:    p = 13'd2602;
      5'd4:    p = 13'd3119;
      5'd5:    p = 13'd3475;
      5'd6:    p = 13'd3707;
      5'd7:    p = 13'd3856;
      5'd8:    p = 13'd3949;
      5'd9:    p = 13'd4006;
      5'd10:   p = 13'd4041;
      5'd11:   p = 13'd4062;
      5'd12:   p = 13'd4076;
      5'd13:   p = 13'd4084;
      5'd14:   p = 13'd4089;
      5'd15:   p = 13'd4091;
      default: p = 13'd4096;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/ernn_ram.sv]
// ----------------------------------------------------------------------------
// ernn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ernn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ernn_ctrl.sv]
// ----------------------------------------------------------------------------
// ernn_ctrl
// Sequencer: clearing sweep, request accept, row/column walk of the step.
// ----------------------------------------------------------------------------
module ernn_ctrl #(
  parameter int MAX_HIDDEN = 16,
  parameter int MAX_INPUT  = 16,
  parameter int MAX_OUTPUT = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     opcode,
  input  logic                           final_element,
  input  logic                           wr_en,
  input  logic [1:0]                     wr_index,
  input  logic [ernn_pkg::LenWidth-1:0]  wr_data,
  output logic                           busy,
  output ernn_pkg::cmd_t                 cmd
);

  localparam int DH = (MAX_HIDDEN < 16) ? MAX_HIDDEN : 16;
  localparam int DX = (MAX_INPUT < 16) ? MAX_INPUT : 16;
  localparam int DY = (MAX_OUTPUT < 16) ? MAX_OUTPUT : 16;

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_HISSUE = 11'b00000000100,
    ST_HDRAIN = 11'b00000001000,
    ST_HFIN1  = 11'b00000010000,
    ST_HFIN2  = 11'b00000100000,
    ST_HFIN3  = 11'b00001000000,
    ST_COPY   = 11'b00010000000,
    ST_YISSUE = 11'b00100000000,
    ST_YDRAIN = 11'b01000000000,
    ST_YEMIT  = 11'b10000000000
  } state_t;

  state_t                            state, state_next;
  logic [ernn_pkg::IdxWidth-1:0]     row, row_next, col, col_next;
  logic                              inp, inp_next;
  logic                              drain, drain_next;
  logic [ernn_pkg::LenWidth-1:0]     in_len, hid_len, out_len;
  logic [ernn_pkg::LenWidth-1:0]     nx, nh, ny;
  logic                              col_end_h, col_end_x, row_end_h, row_end_y;

  function automatic logic [4:0] clamp_len(input logic [4:0] v, input logic [4:0] top);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (v > top) r = top;
    else r = v;
    return r;
  endfunction

  assign nx = clamp_len(in_len, 5'(DX));
  assign nh = clamp_len(hid_len, 5'(DH));
  assign ny = clamp_len(out_len, 5'(DY));

  assign col_end_h = ({1'b0, col} == nh - 5'd1);
  assign col_end_x = ({1'b0, col} == nx - 5'd1);
  assign row_end_h = ({1'b0, row} == nh - 5'd1);
  assign row_end_y = ({1'b0, row} == ny - 5'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_len  <= 5'd16;
      hid_len <= 5'd16;
      out_len <= 5'd16;
    end else if (wr_en) begin
      case (wr_index)
        ernn_pkg::REG_INPUT_LEN:  in_len  <= wr_data;
        ernn_pkg::REG_HIDDEN_LEN: hid_len <= wr_data;
        ernn_pkg::REG_OUTPUT_LEN: out_len <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      row   <= '0;
      col   <= '0;
      inp   <= 1'b0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      inp   <= inp_next;
      drain <= drain_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    inp_next   = inp;
    drain_next = drain;
    cmd        = '0;
    cmd.src    = ernn_pkg::SRC_REC;
    cmd.row    = row;
    cmd.col    = col;
    cmd.nh     = nh;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        col_next  = col + 4'd1;
        if (col == 4'd15) begin
          row_next = row + 4'd1;
          if (row == 4'd15) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        cmd.load = start;
        if (start && final_element && (opcode == ernn_pkg::OP_ELEM)) begin
          state_next = ST_HISSUE;
          row_next   = '0;
          col_next   = '0;
          inp_next   = 1'b0;
        end
      end
      ST_HISSUE: begin
        cmd.issue = 1'b1;
        cmd.src   = inp ? ernn_pkg::SRC_INP : ernn_pkg::SRC_REC;
        col_next  = col + 4'd1;
        if (!inp && col_end_h) begin
          col_next = '0;
          inp_next = 1'b1;
        end else if (inp && col_end_x) begin
          col_next   = '0;
          inp_next   = 1'b0;
          drain_next = 1'b0;
          state_next = ST_HDRAIN;
        end
      end
      ST_HDRAIN: begin
        // wait for the multiply-accumulate pipe to empty
        drain_next = 1'b1;
        if (drain) state_next = ST_HFIN1;
      end
      ST_HFIN1: begin
        cmd.fin1   = 1'b1;
        state_next = ST_HFIN2;
      end
      ST_HFIN2: begin
        cmd.fin2   = 1'b1;
        state_next = ST_HFIN3;
      end
      ST_HFIN3: begin
        cmd.fin3 = 1'b1;
        if (row_end_h) begin
          row_next   = '0;
          state_next = ST_COPY;
        end else begin
          row_next   = row + 4'd1;
          state_next = ST_HISSUE;
        end
      end
      ST_COPY: begin
        cmd.copy   = 1'b1;
        state_next = ST_YISSUE;
      end
      ST_YISSUE: begin
        cmd.issue = 1'b1;
        cmd.src   = ernn_pkg::SRC_OUT;
        col_next  = col + 4'd1;
        if (col_end_h) begin
          col_next   = '0;
          drain_next = 1'b0;
          state_next = ST_YDRAIN;
        end
      end
      ST_YDRAIN: begin
        drain_next = 1'b1;
        if (drain) state_next = ST_YEMIT;
      end
      ST_YEMIT: begin
        cmd.emit = 1'b1;
        cmd.last = row_end_y;
        if (row_end_y) begin
          row_next   = '0;
          state_next = ST_IDLE;
        end else begin
          row_next   = row + 4'd1;
          state_next = ST_YISSUE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/ernn_dpath.sv]
// ----------------------------------------------------------------------------
// ernn_dpath
// Weight RAMs, vector registers, multiply-accumulate pipe, rescale and tanh.
// ----------------------------------------------------------------------------
module ernn_dpath #(
  parameter int MAX_HIDDEN = 16,
  parameter int MAX_INPUT  = 16,
  parameter int MAX_OUTPUT = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ernn_pkg::cmd_t                        cmd,
  input  logic [1:0]                            opcode,
  input  logic [ernn_pkg::IdxWidth-1:0]         row_index,
  input  logic [ernn_pkg::IdxWidth-1:0]         column_index,
  input  logic signed [ernn_pkg::DataWidth-1:0] sample_value,
  output logic signed [ernn_pkg::DataWidth-1:0] output_value,
  output logic [ernn_pkg::IdxWidth-1:0]         output_index,
  output logic                                  output_last,
  output logic                                  result_strobe
);

  localparam int DW = ernn_pkg::DataWidth;
  localparam int AW = ernn_pkg::AccWidth;
  localparam int PW = ernn_pkg::ProdWidth;
  localparam int DH = (MAX_HIDDEN < 16) ? MAX_HIDDEN : 16;
  localparam int DX = (MAX_INPUT < 16) ? MAX_INPUT : 16;
  localparam int DY = (MAX_OUTPUT < 16) ? MAX_OUTPUT : 16;
  localparam int HW = (DH > 1) ? $clog2(DH) : 1;
  localparam int XW = (DX > 1) ? $clog2(DX) : 1;
  localparam int YW = (DY > 1) ? $clog2(DY) : 1;

  logic signed [DW-1:0] hid   [DH];
  logic signed [DW-1:0] fresh [DH];
  logic signed [DW-1:0] xbuf  [DX];

  logic row_in_h, row_in_x, row_in_y, col_in_h, col_in_x;
  logic rec_we, inp_we, out_we;
  logic [HW+HW-1:0] rec_waddr, rec_raddr;
  logic [HW+XW-1:0] inp_waddr, inp_raddr;
  logic [YW+HW-1:0] out_waddr, out_raddr;
  logic [DW-1:0]    wdata, rec_q, inp_q, out_q;

  logic                 s1_valid, s2_valid;
  ernn_pkg::src_t       s1_src;
  logic signed [DW-1:0] vec_q, weight;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc, acc_round;
  logic signed [AW-1:0] shifted;
  logic signed [DW-1:0] sat_val;

  logic signed [DW-1:0] res_q;
  logic [DW:0]          mag;
  logic [12:0]          base, upper, diff;
  logic                 tsat, tneg;
  logic [12:0]          tbase;
  logic [20:0]          tprod;
  logic [12:0]          tmag;
  logic signed [DW-1:0] tval;

  assign row_in_h = ({1'b0, row_index} < 5'(DH));
  assign row_in_x = ({1'b0, row_index} < 5'(DX));
  assign row_in_y = ({1'b0, row_index} < 5'(DY));
  assign col_in_h = ({1'b0, column_index} < 5'(DH));
  assign col_in_x = ({1'b0, column_index} < 5'(DX));

  assign rec_we = cmd.clear | (cmd.load & (opcode == ernn_pkg::OP_REC) & row_in_h & col_in_h);
  assign inp_we = cmd.clear | (cmd.load & (opcode == ernn_pkg::OP_INP) & row_in_h & col_in_x);
  assign out_we = cmd.clear | (cmd.load & (opcode == ernn_pkg::OP_OUT) & row_in_y & col_in_h);

  assign wdata = cmd.clear ? '0 : sample_value;

  // the clear sweep walks the controller's row/column counters
  assign rec_waddr = cmd.clear ? {cmd.row[HW-1:0], cmd.col[HW-1:0]}
                               : {row_index[HW-1:0], column_index[HW-1:0]};
  assign inp_waddr = cmd.clear ? {cmd.row[HW-1:0], cmd.col[XW-1:0]}
                               : {row_index[HW-1:0], column_index[XW-1:0]};
  assign out_waddr = cmd.clear ? {cmd.row[YW-1:0], cmd.col[HW-1:0]}
                               : {row_index[YW-1:0], column_index[HW-1:0]};

  assign rec_raddr = {cmd.row[HW-1:0], cmd.col[HW-1:0]};
  assign inp_raddr = {cmd.row[HW-1:0], cmd.col[XW-1:0]};
  assign out_raddr = {cmd.row[YW-1:0], cmd.col[HW-1:0]};

  ernn_ram #(.WIDTH(DW), .DEPTH(2 ** (HW + HW))) u_rec_ram (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(wdata),
    .raddr(rec_raddr), .rdata(rec_q)
  );

  ernn_ram #(.WIDTH(DW), .DEPTH(2 ** (HW + XW))) u_inp_ram (
    .clk(clk), .we(inp_we), .waddr(inp_waddr), .wdata(wdata),
    .raddr(inp_raddr), .rdata(inp_q)
  );

  ernn_ram #(.WIDTH(DW), .DEPTH(2 ** (YW + HW))) u_out_ram (
    .clk(clk), .we(out_we), .waddr(out_waddr), .wdata(wdata),
    .raddr(out_raddr), .rdata(out_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load && (opcode == ernn_pkg::OP_ELEM) && row_in_x) begin
      xbuf[row_index[XW-1:0]] <= sample_value;
    end
  end

  // stage 0: vector operand alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_src <= cmd.src;
    vec_q  <= (cmd.src == ernn_pkg::SRC_INP) ? xbuf[cmd.col[XW-1:0]] : hid[cmd.col[HW-1:0]];
  end

  always_comb begin
    case (s1_src)
      ernn_pkg::SRC_REC: weight = rec_q;
      ernn_pkg::SRC_INP: weight = inp_q;
      ernn_pkg::SRC_OUT: weight = out_q;
      default:           weight = rec_q;
    endcase
  end

  // stage 1: product
  always_ff @(posedge clk) begin
    prod <= weight * vec_q;
  end

  // stage 2: accumulate; the row result is taken and cleared together
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.fin1 || cmd.emit) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + AW'(prod);
    end
  end

  // round half up, floor shift, saturate to the data range
  assign acc_round = acc + AW'(2 ** (ernn_pkg::FracBits - 1));
  assign shifted   = acc_round >>> ernn_pkg::FracBits;

  always_comb begin
    if (shifted > AW'(2 ** (DW - 1) - 1)) begin
      sat_val = {1'b0, {(DW - 1){1'b1}}};
    end else if (shifted < -AW'(2 ** (DW - 1))) begin
      sat_val = {1'b1, {(DW - 1){1'b0}}};
    end else begin
      sat_val = shifted[DW-1:0];
    end
  end

  // tanh, step 1 magnitude and segment, step 2 interpolation
  assign mag   = res_q[DW-1] ? ((DW + 1)'(0) - {res_q[DW-1], res_q}) : {1'b0, res_q};
  assign base  = ernn_pkg::tanh_point({1'b0, mag[13:10]});
  assign upper = ernn_pkg::tanh_point({1'b0, mag[13:10]} + 5'd1);
  assign diff  = upper - base;

  assign tmag = tsat ? 13'd4096 : (tbase + 13'((tprod + 21'd512) >> 10));
  assign tval = tneg ? (DW'(0) - DW'(tmag)) : DW'(tmag);

  always_ff @(posedge clk) begin
    if (cmd.fin1) begin
      res_q <= sat_val;
    end
    if (cmd.fin2) begin
      tsat  <= (mag >= (DW + 1)'(16384));
      tneg  <= res_q[DW-1];
      tbase <= base;
      tprod <= 21'(diff[10:0] * mag[9:0]);
    end
    if (cmd.fin3) begin
      fresh[cmd.row[HW-1:0]] <= tval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DH; k++) begin
        hid[k] <= '0;
      end
    end else if (cmd.copy) begin
      for (int k = 0; k < DH; k++) begin
        if (5'(k) < cmd.nh) hid[k] <= fresh[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      output_value <= sat_val;
      output_index <= cmd.row;
      output_last  <= cmd.last;
    end
  end

endmodule

[hw/rtl/elman_rnn_step_unit.sv]
// ----------------------------------------------------------------------------
// elman_rnn_step_unit
// One recurrent step h = tanh(Whh*h + Wxh*x), y = Why*h in Q4.12.
// ----------------------------------------------------------------------------
// Requests enter on start while busy is low: weight loads (opcodes 0..2) and
// input elements (opcode 3). An input element with final_element set starts
// the step and raises busy.
// The step runs one shared multiply-accumulate pipe (read, multiply,
// accumulate). Each hidden row issues its nh recurrent and nx input products,
// drains the pipe, rescales and applies tanh; the new hidden vector is then
// copied, and each output row issues nh products, drains the pipe and emits.
// Results appear on output_value/output_index/output_last, each marked by
// result_strobe high for one cycle; the receiver cannot stall.
// Configuration writes (wr_en, wr_index, wr_data) take effect at once.
// After reset the weight RAMs are cleared in a sweep of all 16 x 16 row/column
// pairs with busy high; configuration writes are still taken during it.
// ----------------------------------------------------------------------------
module elman_rnn_step_unit #(
  parameter int MAX_HIDDEN = 16,
  parameter int MAX_INPUT  = 16,
  parameter int MAX_OUTPUT = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            opcode,
  input  logic [ernn_pkg::IdxWidth-1:0]         row_index,
  input  logic [ernn_pkg::IdxWidth-1:0]         column_index,
  input  logic signed [ernn_pkg::DataWidth-1:0] sample_value,
  input  logic                                  final_element,
  input  logic                                  wr_en,
  input  logic [1:0]                            wr_index,
  input  logic [ernn_pkg::LenWidth-1:0]         wr_data,
  output logic                                  result_strobe,
  output logic signed [ernn_pkg::DataWidth-1:0] output_value,
  output logic [ernn_pkg::IdxWidth-1:0]         output_index,
  output logic                                  output_last
);

  ernn_pkg::cmd_t cmd;

  ernn_ctrl #(
    .MAX_HIDDEN(MAX_HIDDEN), .MAX_INPUT(MAX_INPUT), .MAX_OUTPUT(MAX_OUTPUT)
  ) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .final_element(final_element), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data), .busy(busy), .cmd(cmd)
  );

  ernn_dpath #(
    .MAX_HIDDEN(MAX_HIDDEN), .MAX_INPUT(MAX_INPUT), .MAX_OUTPUT(MAX_OUTPUT)
  ) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .opcode(opcode), .row_index(row_index),
    .column_index(column_index), .sample_value(sample_value),
    .output_value(output_value), .output_index(output_index),
    .output_last(output_last), .result_strobe(result_strobe)
  );

endmodule

[hw/rtl/ernn_checker.sv]
// ----------------------------------------------------------------------------
// ernn_checker
// Port-level checks of the recurrent step unit's result sequencing.
// ----------------------------------------------------------------------------
`include "elman_rnn_step_unit_macros.svh"

module ernn_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic result_strobe,
  input logic output_last
);

  // the clearing sweep follows reset
  `ERNN_ASSERT_NEXT(a_busy_after_reset, clk, 1'b0, rst, busy)
  // more results follow a result that is not the last one
  `ERNN_ASSERT_NOW(a_mid_result_busy, clk, rst, result_strobe && !output_last, busy)
  // the last result ends the step
  `ERNN_ASSERT_NOW(a_last_result_idle, clk, rst, result_strobe && output_last, !busy)
  // results are spaced apart by the accumulate pipe
  `ERNN_ASSERT_NEXT(a_result_gap, clk, rst, result_strobe, !result_strobe)

endmodule

bind elman_rnn_step_unit ernn_checker u_ernn_checker (
  .clk(clk), .rst(rst), .busy(busy), .result_strobe(result_strobe),
  .output_last(output_last)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recurrent step unit: loads weight matrices,
// streams input vectors under several length settings and compares every
// output element against a cycle-free fixed-point prediction.
// ----------------------------------------------------------------------------
typedef struct {
  logic signed [15:0] value;
  logic [3:0]         index;
  logic               last;
} y_elem_t;

class step_scoreboard;
  int in_len  = 16;
  int hid_len = 16;
  int out_len = 16;
  logic signed [15:0] hid[16];
  logic signed [15:0] whh[16][16];
  logic signed [15:0] wxh[16][16];
  logic signed [15:0] why[16][16];
  logic signed [15:0] xbuf[16];
  y_elem_t pending_y[$];
  int errors = 0;
  int steps = 0;
  int checked = 0;
  int tanh_tbl[17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
                       4006, 4041, 4062, 4076, 4084, 4089, 4091, 4096};

  function new();
    for (int i = 0; i < 16; i++) begin
      hid[i] = '0;
      xbuf[i] = '0;
      for (int j = 0; j < 16; j++) begin
        whh[i][j] = '0;
        wxh[i][j] = '0;
        why[i][j] = '0;
      end
    end
  endfunction

  function int eff_len(int v);
    if (v < 1) return 1;
    return (v > 16) ? 16 : v;
  endfunction

  function logic signed [15:0] to_q412(longint acc);
    longint q;
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function logic signed [15:0] tanh_q(logic signed [15:0] x);
    int a, r, seg, frac;
    a = (x < 0) ? -int'(x) : int'(x);
    if (a >= 16384) begin
      r = 4096;
    end else begin
      seg = a / 1024;
      frac = a % 1024;
      r = tanh_tbl[seg] + ((tanh_tbl[seg+1] - tanh_tbl[seg]) * frac + 512) / 1024;
    end
    if (x < 0) r = -r;
    return r[15:0];
  endfunction

  function void set_len(ernn_pkg::reg_index_t idx, logic [4:0] v);
    case (idx)
      ernn_pkg::REG_INPUT_LEN:  in_len = v;
      ernn_pkg::REG_HIDDEN_LEN: hid_len = v;
      ernn_pkg::REG_OUTPUT_LEN: out_len = v;
      default: ;
    endcase
  endfunction

  function void note_request(ernn_pkg::opcode_t op, logic [3:0] row, logic [3:0] col,
                             logic signed [15:0] val, logic fin);
    int nx, nh, ny;
    longint acc;
    logic signed [15:0] fresh[16];
    y_elem_t e;
    case (op)
      ernn_pkg::OP_REC: whh[row][col] = val;
      ernn_pkg::OP_INP: wxh[row][col] = val;
      ernn_pkg::OP_OUT: why[row][col] = val;
      default: begin
        xbuf[row] = val;
        if (fin) begin
          nx = eff_len(in_len);
          nh = eff_len(hid_len);
          ny = eff_len(out_len);
          for (int i = 0; i < nh; i++) begin
            acc = 0;
            for (int j = 0; j < nh; j++) acc += longint'(whh[i][j]) * longint'(hid[j]);
            for (int j = 0; j < nx; j++) acc += longint'(wxh[i][j]) * longint'(xbuf[j]);
            fresh[i] = tanh_q(to_q412(acc));
          end
          for (int i = 0; i < nh; i++) hid[i] = fresh[i];
          for (int i = 0; i < ny; i++) begin
            acc = 0;
            for (int j = 0; j < nh; j++) acc += longint'(why[i][j]) * longint'(hid[j]);
            e.value = to_q412(acc);
            e.index = i[3:0];
            e.last = (i + 1 == ny);
            pending_y.push_back(e);
          end
          steps++;
        end
      end
    endcase
  endfunction

  function void check_result(logic signed [15:0] v, logic [3:0] idx, logic last);
    y_elem_t e;
    if (pending_y.size() == 0) begin
      $display("%0t: unexpected result value=%0d index=%0d last=%0b", $time, v, idx, last);
      errors++;
      return;
    end
    e = pending_y.pop_front();
    checked++;
    if (v !== e.value) begin
      $display("%0t: output_value expected %0d actual %0d", $time, e.value, v);
      errors++;
    end
    if (idx !== e.index) begin
      $display("%0t: output_index expected %0d actual %0d", $time, e.index, idx);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t: output_last expected %0b actual %0b", $time, e.last, last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int CycleLimit = 3000000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         opcode;
  logic [3:0]         row_index;
  logic [3:0]         column_index;
  logic signed [15:0] sample_value;
  logic               final_element;
  logic               wr_en;
  logic [1:0]         wr_index;
  logic [4:0]         wr_data;
  logic               result_strobe;
  logic signed [15:0] output_value;
  logic [3:0]         output_index;
  logic               output_last;

  step_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  int sent = 0;
  logic [15:0] x_written = '0;

  elman_rnn_step_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .row_index(row_index), .column_index(column_index),
    .sample_value(sample_value), .final_element(final_element),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .result_strobe(result_strobe), .output_value(output_value),
    .output_index(output_index), .output_last(output_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(output_value, output_index, output_last);
  end

  function int x_len();
    return sb.eff_len(sb.in_len);
  endfunction

  // Issue one request, hold it until accepted, then idle per the burst pattern.
  task automatic send(ernn_pkg::opcode_t op, logic [3:0] row, logic [3:0] col,
                      logic signed [15:0] val, logic fin);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    opcode <= op;
    row_index <= row;
    column_index <= col;
    sample_value <= val;
    final_element <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, row, col, val, fin);
    if (op == ernn_pkg::OP_ELEM) x_written[row] = 1'b1;
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(1, 30);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_y.size() != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_len(ernn_pkg::reg_index_t idx, logic [4:0] v);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    @(posedge clk);
    sb.set_len(idx, v);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_lengths(logic [4:0] nx, logic [4:0] nh, logic [4:0] ny);
    wait_idle();
    write_len(ernn_pkg::REG_INPUT_LEN, nx);
    write_len(ernn_pkg::REG_HIDDEN_LEN, nh);
    write_len(ernn_pkg::REG_OUTPUT_LEN, ny);
  endtask

  task automatic send_vector();
    int n;
    n = x_len();
    for (int i = 0; i < n; i++)
      send(ernn_pkg::OP_ELEM, i[3:0], 4'($urandom), 16'($urandom), i == n - 1);
  endtask

  // Mostly well-formed: a few weight loads then one full vector; else noise.
  task automatic random_traffic(int count);
    int start_cnt;
    logic fin;
    ernn_pkg::opcode_t op;
    start_cnt = sent;
    while (sent - start_cnt < count) begin
      if ($urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(0, 16)) begin
          op = ernn_pkg::opcode_t'($urandom_range(0, 2));
          send(op, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
        end
        send_vector();
      end else begin
        op = ernn_pkg::opcode_t'($urandom_range(0, 3));
        fin = 1'($urandom);
        // drop the final mark unless every element in use has been written
        if (op == ernn_pkg::OP_ELEM && fin) begin
          for (int i = 0; i < x_len(); i++)
            if (!x_written[i] && i != 0) fin = 1'b0;
        end
        send(op, (op == ernn_pkg::OP_ELEM && fin) ? 4'd0 : 4'($urandom), 4'($urandom),
             16'($urandom), fin);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    opcode = ernn_pkg::OP_REC;
    row_index = '0;
    column_index = '0;
    sample_value = '0;
    final_element = 1'b0;
    wr_en = 1'b0;
    wr_index = ernn_pkg::REG_INPUT_LEN;
    wr_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes of weights and elements at full size
    set_lengths(5'd16, 5'd16, 5'd16);
    send(ernn_pkg::OP_REC, 4'd0, 4'd0, 16'sh7fff, 1'b1);
    send(ernn_pkg::OP_REC, 4'd15, 4'd15, -16'sh8000, 1'b0);
    send(ernn_pkg::OP_INP, 4'd0, 4'd15, 16'sh7fff, 1'b0);
    send(ernn_pkg::OP_INP, 4'd15, 4'd0, -16'sh8000, 1'b0);
    send(ernn_pkg::OP_INP, 4'd3, 4'd3, 16'sh1000, 1'b0);
    send(ernn_pkg::OP_OUT, 4'd0, 4'd0, 16'sh7fff, 1'b1);
    send(ernn_pkg::OP_OUT, 4'd15, 4'd15, -16'sh8000, 1'b0);
    send(ernn_pkg::OP_OUT, 4'd3, 4'd3, 16'sh1000, 1'b0);
    for (int i = 0; i < 16; i++)
      send(ernn_pkg::OP_ELEM, i[3:0], 4'd15, (i % 2) ? 16'sh7fff : -16'sh8000, i == 15);
    random_traffic(40);

    // lengths of one, zero (treated as one), and oversized (clamped)
    set_lengths(5'd1, 5'd1, 5'd1);
    send(ernn_pkg::OP_ELEM, 4'd0, 4'd0, 16'sh7fff, 1'b1);
    random_traffic(30);
    set_lengths(5'd0, 5'd0, 5'd0);
    random_traffic(30);
    set_lengths(5'd31, 5'd31, 5'd31);
    random_traffic(40);
    set_lengths(5'd5, 5'd7, 5'd3);
    random_traffic(40);
    repeat (3) begin
      set_lengths(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)));
      random_traffic(35);
    end

    wait_idle();
    $display("Sent %0d requests, ran %0d steps, checked %0d output elements.",
             sent, sb.steps, sb.checked);
    $display("Lengths swept from zero through oversized, with bursty request gaps.");
    if (sb.errors == 0 && sb.pending_y.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ernn_pkg.sv
hw/rtl/ernn_ram.sv
hw/rtl/ernn_ctrl.sv
hw/rtl/ernn_dpath.sv
hw/rtl/elman_rnn_step_unit.sv
hw/rtl/ernn_checker.sv
bench/tb_top.sv
